FILE: rtl/fmtg_pkg.sv
// Shared types and constants for the flight mode throttle governor.
// No dependencies; every other file imports this package.
package fmtg_pkg;

    // Flight modes as held in the mode register and sent in the result word
    typedef enum logic [1:0] {
        MODE_NORMAL = 2'd0,
        MODE_CLIMB  = 2'd1,
        MODE_STALL  = 2'd2
    } t_mode;

    // Register index, taken from paddr[4:2]
    typedef enum logic [2:0] {
        REG_REF_ALT    = 3'd0,
        REG_CLIMB_MARG = 3'd1,
        REG_STALL_SPD  = 3'd2,
        REG_EXIT_SPD   = 3'd3,
        REG_PERSIST    = 3'd4,
        REG_CRUISE     = 3'd5,
        REG_MIN_THR    = 3'd6,
        REG_THR_STEP   = 3'd7
    } t_reg_idx;

    // Configuration as seen by the datapath; reference_altitude is two's complement
    typedef struct packed {
        logic [20:0] reference_altitude;
        logic [19:0] climb_margin;
        logic [19:0] stall_trip_speed;
        logic [19:0] stall_exit_speed;
        logic [15:0] persistence_ticks;
        logic [9:0]  cruise_throttle;
        logic [9:0]  thr_floor;
        logic [9:0]  throttle_step;
    } t_cfg;

    localparam logic [20:0] RST_REF_ALT    = 21'd50000;
    localparam logic [19:0] RST_CLIMB_MARG = 20'd1000;
    localparam logic [19:0] RST_STALL_SPD  = 20'd30000;
    localparam logic [19:0] RST_EXIT_SPD   = 20'd35000;
    localparam logic [15:0] RST_PERSIST    = 16'd100;
    localparam logic [9:0]  RST_CRUISE     = 10'd600;
    localparam logic [9:0]  RST_MIN_THR    = 10'd400;
    localparam logic [9:0]  RST_THR_STEP   = 10'd1;
    localparam logic [9:0]  RST_THROTTLE   = 10'd600;

    localparam logic [9:0]  FULL_THROTTLE  = 10'd1000;
    localparam logic [21:0] CLIMB_PITCH    = 22'd200;
    localparam logic [15:0] COUNT_MAX      = 16'hFFFF;

    // Saturating persistence count: clear when the condition drops
    function automatic logic [15:0] f_count(input logic [15:0] c, input logic cond);
        logic [15:0] r;
        if (!cond) begin
            r = '0;
        end else if (c == COUNT_MAX) begin
            r = COUNT_MAX;
        end else begin
            r = c + 16'd1;
        end
        return r;
    endfunction

endpackage

FILE: rtl/fmtg_cfg.sv
// APB register file for the governor settings.
// Depends on fmtg_pkg for the register layout and reset values.
module fmtg_cfg
    import fmtg_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_psel,
    input  logic        i_penable,
    input  logic        i_pwrite,
    input  logic [4:0]  i_paddr,
    input  logic [31:0] i_pwdata,
    output logic [31:0] o_prdata,
    output t_cfg        o_cfg
);

    t_cfg     r_cfg;
    t_reg_idx w_idx;
    logic     w_wr;

    assign w_idx = t_reg_idx'(i_paddr[4:2]);
    assign w_wr  = i_psel & i_penable & i_pwrite;

    // Write the addressed register on the access cycle
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.reference_altitude <= RST_REF_ALT;
            r_cfg.climb_margin       <= RST_CLIMB_MARG;
            r_cfg.stall_trip_speed   <= RST_STALL_SPD;
            r_cfg.stall_exit_speed   <= RST_EXIT_SPD;
            r_cfg.persistence_ticks  <= RST_PERSIST;
            r_cfg.cruise_throttle    <= RST_CRUISE;
            r_cfg.thr_floor          <= RST_MIN_THR;
            r_cfg.throttle_step      <= RST_THR_STEP;
        end else if (w_wr) begin
            case (w_idx)
                REG_REF_ALT:    r_cfg.reference_altitude <= i_pwdata[20:0];
                REG_CLIMB_MARG: r_cfg.climb_margin       <= i_pwdata[19:0];
                REG_STALL_SPD:  r_cfg.stall_trip_speed   <= i_pwdata[19:0];
                REG_EXIT_SPD:   r_cfg.stall_exit_speed   <= i_pwdata[19:0];
                REG_PERSIST:    r_cfg.persistence_ticks  <= i_pwdata[15:0];
                REG_CRUISE:     r_cfg.cruise_throttle    <= i_pwdata[9:0];
                REG_MIN_THR:    r_cfg.thr_floor          <= i_pwdata[9:0];
                REG_THR_STEP:   r_cfg.throttle_step      <= i_pwdata[9:0];
                default: ;
            endcase
        end
    end

    // Read back; the reference altitude comes back sign extended
    always_comb begin
        case (w_idx)
            REG_REF_ALT:    o_prdata = {{11{r_cfg.reference_altitude[20]}},
                                        r_cfg.reference_altitude};
            REG_CLIMB_MARG: o_prdata = {12'd0, r_cfg.climb_margin};
            REG_STALL_SPD:  o_prdata = {12'd0, r_cfg.stall_trip_speed};
            REG_EXIT_SPD:   o_prdata = {12'd0, r_cfg.stall_exit_speed};
            REG_PERSIST:    o_prdata = {16'd0, r_cfg.persistence_ticks};
            REG_CRUISE:     o_prdata = {22'd0, r_cfg.cruise_throttle};
            REG_MIN_THR:    o_prdata = {22'd0, r_cfg.thr_floor};
            REG_THR_STEP:   o_prdata = {22'd0, r_cfg.throttle_step};
            default:        o_prdata = '0;
        endcase
    end

    assign o_cfg = r_cfg;

endmodule

FILE: rtl/fmtg_mode.sv
// Persistence counters and the flight mode register.
// Depends on fmtg_pkg for the mode codes, settings struct and counter function.
module fmtg_mode
    import fmtg_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_en,
    input  logic [20:0] i_alt,
    input  logic [19:0] i_spd,
    input  t_cfg        i_cfg,
    output t_mode       o_mode
);

    t_mode       r_mode;
    t_mode       n_mode;
    logic [15:0] r_ce_cnt, r_cl_cnt, r_se_cnt, r_sl_cnt;
    logic [15:0] n_ce_cnt, n_cl_cnt, n_se_cnt, n_sl_cnt;
    logic [22:0] w_alt_x, w_ref_x, w_alt_marg;
    logic        w_climb_in, w_climb_out, w_stall_in, w_stall_out;
    logic        w_ce_ge, w_cl_ge, w_se_ge, w_sl_ge;

    // Conditions at full precision
    assign w_alt_x     = {{2{i_alt[20]}}, i_alt};
    assign w_ref_x     = {{2{i_cfg.reference_altitude[20]}}, i_cfg.reference_altitude};
    assign w_alt_marg  = w_alt_x + {3'd0, i_cfg.climb_margin};
    assign w_climb_in  = $signed(w_ref_x) > $signed(w_alt_marg);
    assign w_climb_out = $signed(w_alt_x) >= $signed(w_ref_x);
    assign w_stall_in  = i_spd < i_cfg.stall_trip_speed;
    assign w_stall_out = i_spd > i_cfg.stall_exit_speed;

    // Advance the counters
    assign n_ce_cnt = f_count(r_ce_cnt, w_climb_in);
    assign n_cl_cnt = f_count(r_cl_cnt, w_climb_out);
    assign n_se_cnt = f_count(r_se_cnt, w_stall_in);
    assign n_sl_cnt = f_count(r_sl_cnt, w_stall_out);

    assign w_ce_ge = n_ce_cnt >= i_cfg.persistence_ticks;
    assign w_cl_ge = n_cl_cnt >= i_cfg.persistence_ticks;
    assign w_se_ge = n_se_cnt >= i_cfg.persistence_ticks;
    assign w_sl_ge = n_sl_cnt >= i_cfg.persistence_ticks;

    // Pick the next mode: stall recovery first, then climb, then normal
    always_comb begin
        n_mode = r_mode;
        if (w_se_ge) begin
            n_mode = MODE_STALL;
        end else if (r_mode == MODE_STALL && w_sl_ge) begin
            n_mode = w_ce_ge ? MODE_CLIMB : MODE_NORMAL;
        end else if (w_ce_ge && r_mode != MODE_STALL) begin
            n_mode = MODE_CLIMB;
        end else if (r_mode == MODE_CLIMB && w_cl_ge) begin
            n_mode = MODE_NORMAL;
        end
    end

    // Hold state between ticks
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode   <= MODE_NORMAL;
            r_ce_cnt <= '0;
            r_cl_cnt <= '0;
            r_se_cnt <= '0;
            r_sl_cnt <= '0;
        end else if (i_en) begin
            r_mode   <= n_mode;
            r_ce_cnt <= n_ce_cnt;
            r_cl_cnt <= n_cl_cnt;
            r_se_cnt <= n_se_cnt;
            r_sl_cnt <= n_sl_cnt;
        end
    end

    assign o_mode = n_mode;

endmodule

FILE: rtl/fmtg_thr.sv
// Pitch command and slew-limited throttle for one tick.
// Depends on fmtg_pkg for the mode codes, settings struct and limits.
module fmtg_thr
    import fmtg_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_en,
    input  t_mode       i_mode,
    input  logic [20:0] i_alt,
    input  t_cfg        i_cfg,
    output logic [21:0] o_pitch,
    output logic [9:0]  o_thr
);

    logic [9:0]  r_thr;
    logic [9:0]  n_thr;
    logic [21:0] w_err;
    logic [9:0]  w_tgt_raw, w_tgt_hi, w_tgt;
    logic [10:0] w_up_lim, w_tgt_plus;
    logic        w_up, w_down;

    // Altitude error in pitch units equals the raw altitude difference
    assign w_err = {i_cfg.reference_altitude[20], i_cfg.reference_altitude}
                 - {i_alt[20], i_alt};

    // Mode targets
    always_comb begin
        case (i_mode)
            MODE_STALL: begin
                o_pitch   = w_err[21] ? w_err : '0;
                w_tgt_raw = FULL_THROTTLE;
            end
            MODE_CLIMB: begin
                o_pitch   = CLIMB_PITCH;
                w_tgt_raw = FULL_THROTTLE;
            end
            default: begin
                o_pitch   = w_err;
                w_tgt_raw = i_cfg.cruise_throttle;
            end
        endcase
    end

    // Clamp to full throttle, then the lower bound wins
    assign w_tgt_hi = (w_tgt_raw > FULL_THROTTLE) ? FULL_THROTTLE : w_tgt_raw;
    assign w_tgt    = (w_tgt_hi < i_cfg.thr_floor) ? i_cfg.thr_floor : w_tgt_hi;

    // Move toward the target by at most one step
    assign w_up_lim   = {1'b0, r_thr} + {1'b0, i_cfg.throttle_step};
    assign w_tgt_plus = {1'b0, w_tgt} + {1'b0, i_cfg.throttle_step};
    assign w_up       = {1'b0, w_tgt} > w_up_lim;
    assign w_down     = w_tgt_plus < {1'b0, r_thr};

    always_comb begin
        if (w_up) begin
            n_thr = w_up_lim[9:0];
        end else if (w_down) begin
            n_thr = r_thr - i_cfg.throttle_step;
        end else begin
            n_thr = w_tgt;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_thr <= RST_THROTTLE;
        end else if (i_en) begin
            r_thr <= n_thr;
        end
    end

    assign o_thr = n_thr;

    // Throttle only moves on a tick, and never by more than one step
    a_thr_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !i_en |=> $stable(r_thr))
        else $error("throttle moved without a tick");
    a_thr_rise: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_en |=> ({1'b0, r_thr} <= {1'b0, $past(r_thr)} + {1'b0, $past(i_cfg.throttle_step)}))
        else $error("throttle rose by more than one step");
    a_thr_fall: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_en |=> ({1'b0, r_thr} + {1'b0, $past(i_cfg.throttle_step)} >= {1'b0, $past(r_thr)}))
        else $error("throttle fell by more than one step");

endmodule

FILE: rtl/flight_mode_throttle_governor.sv
// Flight mode and throttle governor.
// Usage:
//   s_axis carries one control tick per word: measured altitude and airspeed.
//   m_axis returns one word per tick: flight mode, pitch command, throttle.
//   The APB port sets the reference altitude, thresholds, persistence
//   length and throttle limits; write it only while no tick is in flight.
// Timing:
//   A tick passes an input register, then the compare, count and slew
//   logic that updates the mode, counters and throttle and loads the
//   output register, which raises m_axis_tvalid.
//   One tick per cycle is sustained while m_axis_tready stays high; the
//   state feedback through the counters, mode and throttle registers closes through combinational logic alone.
// Reset:
//   Synchronous, active low. Mode normal, counters zero, throttle 600,
//   settings at their defaults, both pipeline registers empty.
// Stall:
//   While m_axis_tready is low the output word holds; the input register
//   still takes one more word, after which s_axis_tready drops.
// Depends on fmtg_pkg, fmtg_cfg, fmtg_mode and fmtg_thr.
module flight_mode_throttle_governor
    import fmtg_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [47:0] s_axis_tdata,  // [20:0] measured_altitude, [40:21] measured_speed
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [39:0] m_axis_tdata,  // [1:0] flight_mode, [23:2] pitch_command,
                                       // [33:24] throttle_command
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [4:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);

    t_cfg        w_cfg;
    logic        r_in_valid;
    logic [20:0] r_alt;
    logic [19:0] r_spd;
    logic        r_out_valid;
    t_mode       r_out_mode;
    logic [21:0] r_out_pitch;
    logic [9:0]  r_out_thr;
    logic        w_adv;
    t_mode       w_mode;
    logic [21:0] w_pitch;
    logic [9:0]  w_thr;

    assign pready = 1'b1;

    fmtg_cfg u_cfg (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_psel    (psel),
        .i_penable (penable),
        .i_pwrite  (pwrite),
        .i_paddr   (paddr),
        .i_pwdata  (pwdata),
        .o_prdata  (prdata),
        .o_cfg     (w_cfg)
    );

    // Advance a tick when the output register is free or being drained
    assign w_adv         = r_in_valid & (~r_out_valid | m_axis_tready);
    assign s_axis_tready = ~r_in_valid | w_adv;

    // Input register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (s_axis_tready) begin
            r_in_valid <= s_axis_tvalid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s_axis_tvalid & s_axis_tready) begin
            r_alt <= s_axis_tdata[20:0];
            r_spd <= s_axis_tdata[40:21];
        end
    end

    fmtg_mode u_mode (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (w_adv),
        .i_alt   (r_alt),
        .i_spd   (r_spd),
        .i_cfg   (w_cfg),
        .o_mode  (w_mode)
    );

    fmtg_thr u_thr (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (w_adv),
        .i_mode  (w_mode),
        .i_alt   (r_alt),
        .i_cfg   (w_cfg),
        .o_pitch (w_pitch),
        .o_thr   (w_thr)
    );

    // Output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_adv) begin
            r_out_valid <= 1'b1;
        end else if (m_axis_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            r_out_mode  <= w_mode;
            r_out_pitch <= w_pitch;
            r_out_thr   <= w_thr;
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = {6'd0, r_out_thr, r_out_pitch, r_out_mode};

    // Climb sends the fixed pitch; stall recovery never commands nose up
    a_climb_pitch: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && r_out_mode == MODE_CLIMB) |-> (r_out_pitch == CLIMB_PITCH))
        else $error("climb word without climb pitch");
    a_stall_pitch: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && r_out_mode == MODE_STALL) |-> (r_out_pitch[21] || r_out_pitch == '0))
        else $error("positive pitch in stall recovery");
    a_no_drop: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && !m_axis_tready) |=> (r_out_valid && $stable(r_out_thr)))
        else $error("output word lost while stalled");

endmodule
